// ----- rtl/core/mips_subset_decode_execute_defines.svh -----
// Assertion macros for the MIPS subset decode/execute block.
// Included by the checker; no other dependencies.
`ifndef MIPS_SUBSET_DECODE_EXECUTE_DEFINES_SVH
`define MIPS_SUBSET_DECODE_EXECUTE_DEFINES_SVH

// Clocked property, disabled while reset is high.
`define MIPSDE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define MIPSDE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mipsde_pkg.sv -----
// Shared types and constants for the MIPS subset decode/execute block.
// No dependencies.
package mipsde_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [REG_W-1:0]  reg_idx_t;

  // Link register for JAL
  localparam reg_idx_t REG_RA = 5'd31;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'h00,
    OP_J       = 6'h02,
    OP_JAL     = 6'h03,
    OP_BEQ     = 6'h04,
    OP_BNE     = 6'h05,
    OP_ADDIU   = 6'h09,
    OP_SLTIU   = 6'h0b,
    OP_ANDI    = 6'h0c,
    OP_ORI     = 6'h0d,
    OP_LUI     = 6'h0f,
    OP_LB      = 6'h20,
    OP_LW      = 6'h23,
    OP_SB      = 6'h28,
    OP_SW      = 6'h2b
  } opcode_t;

  typedef enum logic [5:0] {
    FN_SLL  = 6'h00,
    FN_SRL  = 6'h02,
    FN_JR   = 6'h08,
    FN_ADDU = 6'h21,
    FN_SUBU = 6'h23,
    FN_AND  = 6'h24,
    FN_OR   = 6'h25,
    FN_NOR  = 6'h27,
    FN_SLTU = 6'h2b
  } funct_t;

  typedef enum logic [2:0] {
    MEM_NONE = 3'd0,
    MEM_LW   = 3'd1,
    MEM_LB   = 3'd2,
    MEM_SW   = 3'd3,
    MEM_SB   = 3'd4
  } mem_kind_t;

endpackage

// ----- rtl/core/mipsde_in_if.sv -----
// Instruction channel: valid/ready plus instruction word, address, operands.
// Depends on mipsde_pkg.
interface mipsde_in_if;
  logic              valid;
  logic              ready;
  mipsde_pkg::word_t instr_word;
  mipsde_pkg::word_t instr_addr;
  mipsde_pkg::word_t src_a_value;
  mipsde_pkg::word_t src_b_value;

  modport source (output valid, instr_word, instr_addr, src_a_value, src_b_value,
                  input ready);
  modport sink   (input valid, instr_word, instr_addr, src_a_value, src_b_value,
                  output ready);
endinterface

// ----- rtl/core/mipsde_out_if.sv -----
// Result channel: valid/ready plus decoded/executed result fields.
// Depends on mipsde_pkg.
interface mipsde_out_if;
  logic                 valid;
  logic                 ready;
  mipsde_pkg::word_t    exec_value;
  mipsde_pkg::reg_idx_t dest_reg;
  logic                 reg_write;
  logic [2:0]           mem_kind;
  mipsde_pkg::word_t    store_data;
  mipsde_pkg::word_t    next_pc;
  logic                 redirect;
  logic                 illegal;

  modport source (output valid, exec_value, dest_reg, reg_write, mem_kind,
                  store_data, next_pc, redirect, illegal, input ready);
  modport sink   (input valid, exec_value, dest_reg, reg_write, mem_kind,
                  store_data, next_pc, redirect, illegal, output ready);
endinterface

// ----- rtl/core/mips_subset_decode_execute.sv -----
// MIPS32 subset decode and execute stage. An accepted input transaction passes
// the input register and then the result register before its result transaction.
// Throughput: one transaction per cycle while result.ready holds; set by the
// single decode/ALU pass between the two registers. Both stages advance when the next one is free.
// Reset (rst, synchronous): clears both valid flags; payload is not reset.
// Depends on mipsde_pkg, mipsde_in_if, mipsde_out_if.
module mips_subset_decode_execute (
  input  logic         clk,
  input  logic         rst,
  mipsde_in_if.sink    instr,
  mipsde_out_if.source result
);
  import mipsde_pkg::*;

  // ---------------------------------------------------------------------
  // Handshake: each stage loads when it is empty or its content leaves.
  // ---------------------------------------------------------------------
  logic out_valid;
  logic s1_valid;
  logic out_load;
  logic s1_load;

  assign out_load    = !out_valid || result.ready;
  assign s1_load     = !s1_valid || out_load;
  assign instr.ready = s1_load;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  word_t s1_word;
  word_t s1_addr;
  word_t s1_a;
  word_t s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && instr.valid) begin
      s1_word <= instr.instr_word;
      s1_addr <= instr.instr_addr;
      s1_a    <= instr.src_a_value;
      s1_b    <= instr.src_b_value;
    end
  end

  // ---------------------------------------------------------------------
  // Field extraction
  // ---------------------------------------------------------------------
  logic [5:0]  op;
  logic [5:0]  fn;
  reg_idx_t    rt;
  reg_idx_t    rd;
  logic [4:0]  sh;
  logic [15:0] imm;
  word_t       simm;
  word_t       zimm;
  word_t       pc4;
  word_t       br_target;
  word_t       j_target;

  assign op   = s1_word[31:26];
  assign fn   = s1_word[5:0];
  assign rt   = s1_word[20:16];
  assign rd   = s1_word[15:11];
  assign sh   = s1_word[10:6];
  assign imm  = s1_word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'h0000, imm};
  assign pc4  = s1_addr + 32'd4;

  // Branch offset is in words, sign-extended; jump keeps the 256 MB segment.
  assign br_target = pc4 + {simm[29:0], 2'b00};
  assign j_target  = {pc4[31:28], s1_word[25:0], 2'b00};

  // ---------------------------------------------------------------------
  // Decode and execute
  // ---------------------------------------------------------------------
  word_t     exec_value_next;
  reg_idx_t  dest_reg_next;
  logic      reg_write_next;
  mem_kind_t mem_kind_next;
  word_t     store_data_next;
  word_t     next_pc_next;
  logic      redirect_next;
  logic      illegal_next;
  logic      taken;
  word_t     ea;

  assign ea = s1_a + simm;

  always_comb begin
    exec_value_next = '0;
    dest_reg_next   = '0;
    reg_write_next  = 1'b0;
    mem_kind_next   = MEM_NONE;
    store_data_next = '0;
    next_pc_next    = pc4;
    redirect_next   = 1'b0;
    illegal_next    = 1'b0;
    taken           = 1'b0;

    case (opcode_t'(op))
      OP_SPECIAL: begin
        dest_reg_next  = rd;
        reg_write_next = 1'b1;
        case (funct_t'(fn))
          FN_ADDU: exec_value_next = s1_a + s1_b;
          FN_SUBU: exec_value_next = s1_a - s1_b;
          FN_AND:  exec_value_next = s1_a & s1_b;
          FN_OR:   exec_value_next = s1_a | s1_b;
          FN_NOR:  exec_value_next = ~(s1_a | s1_b);
          FN_SLTU: exec_value_next = {31'd0, s1_a < s1_b};
          FN_SLL:  exec_value_next = s1_b << sh;
          FN_SRL:  exec_value_next = s1_b >> sh;
          FN_JR: begin
            dest_reg_next  = '0;
            reg_write_next = 1'b0;
            next_pc_next   = s1_a;
            redirect_next  = 1'b1;
          end
          default: begin
            dest_reg_next  = '0;
            reg_write_next = 1'b0;
            illegal_next   = 1'b1;
          end
        endcase
      end
      OP_ADDIU: begin
        exec_value_next = ea;
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
      end
      OP_ANDI: begin
        exec_value_next = s1_a & zimm;
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
      end
      OP_ORI: begin
        exec_value_next = s1_a | zimm;
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
      end
      OP_LUI: begin
        exec_value_next = {imm, 16'h0000};
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
      end
      OP_SLTIU: begin
        exec_value_next = {31'd0, s1_a < simm};
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
      end
      OP_LW: begin
        exec_value_next = ea;
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
        mem_kind_next   = MEM_LW;
      end
      OP_LB: begin
        exec_value_next = ea;
        dest_reg_next   = rt;
        reg_write_next  = 1'b1;
        mem_kind_next   = MEM_LB;
      end
      OP_SW: begin
        exec_value_next = ea;
        mem_kind_next   = MEM_SW;
        store_data_next = s1_b;
      end
      OP_SB: begin
        exec_value_next = ea;
        mem_kind_next   = MEM_SB;
        store_data_next = s1_b;
      end
      OP_BEQ, OP_BNE: begin
        exec_value_next = s1_a - s1_b;
        taken = (s1_a == s1_b) ^ (opcode_t'(op) == OP_BNE);
        if (taken) begin
          next_pc_next  = br_target;
          redirect_next = 1'b1;
        end
      end
      OP_J: begin
        next_pc_next  = j_target;
        redirect_next = 1'b1;
      end
      OP_JAL: begin
        exec_value_next = pc4;
        dest_reg_next   = REG_RA;
        reg_write_next  = 1'b1;
        next_pc_next    = j_target;
        redirect_next   = 1'b1;
      end
      default: begin
        illegal_next = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      result.exec_value <= exec_value_next;
      result.dest_reg   <= dest_reg_next;
      result.reg_write  <= reg_write_next;
      result.mem_kind   <= mem_kind_next;
      result.store_data <= store_data_next;
      result.next_pc    <= next_pc_next;
      result.redirect   <= redirect_next;
      result.illegal    <= illegal_next;
    end
  end

  assign result.valid = out_valid;

endmodule

// ----- rtl/core/mipsde_checker.sv -----
// Port-level checks for mips_subset_decode_execute, attached by bind.
// Depends on mipsde_pkg and mips_subset_decode_execute_defines.svh.
`include "mips_subset_decode_execute_defines.svh"

module mipsde_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       reg_write,
  input logic [2:0] mem_kind,
  input logic       redirect,
  input logic       illegal
);
  import mipsde_pkg::*;

  // Reset empties the result stage.
  `MIPSDE_ASSERT_RST(a_rst_clears, clk, rst |=> !out_valid, "result valid after reset")

  // A pending result transaction is not withdrawn.
  `MIPSDE_ASSERT(a_valid_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result valid dropped")

  // Unsupported instructions have no side effects.
  `MIPSDE_ASSERT(a_illegal_quiet, clk, rst, out_valid && illegal |-> !reg_write && !redirect && mem_kind == MEM_NONE, "illegal with side effect")

  // Stores never write a register.
  `MIPSDE_ASSERT(a_store_no_write, clk, rst, out_valid |-> (mem_kind != MEM_SW && mem_kind != MEM_SB) || !reg_write, "store writes register")

endmodule

bind mips_subset_decode_execute mipsde_checker u_mipsde_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .reg_write (result.reg_write),
  .mem_kind  (result.mem_kind),
  .redirect  (result.redirect),
  .illegal   (result.illegal)
);

// ----- tb/mips_subset_decode_execute_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the MIPS subset decode/execute stage.
// Depends on mipsde_pkg, mipsde_in_if, mipsde_out_if and mips_subset_decode_execute.
module mips_subset_decode_execute_test;
  import mipsde_pkg::*;

  // Run ends here no matter what; the slowest legal run is far below this.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to keep watching the result channel after the last expected result.
  localparam int unsigned DRAIN_CYCLES = 10;

  // Encodings the block does not support: used to reach the illegal path.
  localparam logic [5:0] OP_UNUSED = 6'h3f;
  localparam logic [5:0] FN_UNUSED = 6'h01;

  // One predicted result transaction, field for field as on the result channel.
  typedef struct packed {
    word_t     exec_value;
    reg_idx_t  dest_reg;
    logic      reg_write;
    mem_kind_t mem_kind;
    word_t     store_data;
    word_t     next_pc;
    logic      redirect;
    logic      illegal;
  } exec_result_t;

  logic clk;
  logic rst;

  mipsde_in_if  instr_if ();
  mipsde_out_if result_if ();

  mips_subset_decode_execute dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_if),
    .result (result_if)
  );

  // Predicted results, oldest first, in the order instructions were accepted.
  exec_result_t exec_results_q[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  // When clear, neither side inserts gaps or stalls.
  bit           pacing_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: decode plus ALU / branch / jump resolution for one instruction
  // ---------------------------------------------------------------------
  function automatic exec_result_t execute_instr(word_t iw, word_t pc, word_t a, word_t b);
    exec_result_t r;
    word_t        pc4;
    word_t        simm;
    word_t        zimm;
    logic [4:0]   shamt;
    pc4   = pc + 32'd4;
    simm  = {{16{iw[15]}}, iw[15:0]};
    zimm  = {16'h0000, iw[15:0]};
    shamt = iw[10:6];
    r          = '0;
    r.mem_kind = MEM_NONE;
    r.next_pc  = pc4;
    if (iw[31:26] == OP_SPECIAL) begin
      // R-type writes rd unless the funct says otherwise
      r.dest_reg  = iw[15:11];
      r.reg_write = 1'b1;
      case (iw[5:0])
        FN_ADDU: r.exec_value = a + b;
        FN_SUBU: r.exec_value = a - b;
        FN_AND:  r.exec_value = a & b;
        FN_OR:   r.exec_value = a | b;
        FN_NOR:  r.exec_value = ~(a | b);
        FN_SLTU: r.exec_value = (a < b) ? 32'd1 : 32'd0;
        FN_SLL:  r.exec_value = b << shamt;
        FN_SRL:  r.exec_value = b >> shamt;
        FN_JR: begin
          r.dest_reg  = '0;
          r.reg_write = 1'b0;
          r.next_pc   = a;
          r.redirect  = 1'b1;
        end
        default: begin
          r.dest_reg  = '0;
          r.reg_write = 1'b0;
          r.illegal   = 1'b1;
        end
      endcase
    end else begin
      // I-type writes rt unless the opcode says otherwise
      r.dest_reg  = iw[20:16];
      r.reg_write = 1'b1;
      case (iw[31:26])
        OP_ADDIU: r.exec_value = a + simm;
        OP_ANDI:  r.exec_value = a & zimm;
        OP_ORI:   r.exec_value = a | zimm;
        OP_LUI:   r.exec_value = {iw[15:0], 16'h0000};
        OP_SLTIU: r.exec_value = (a < simm) ? 32'd1 : 32'd0;
        OP_LW: begin
          r.exec_value = a + simm;
          r.mem_kind   = MEM_LW;
        end
        OP_LB: begin
          r.exec_value = a + simm;
          r.mem_kind   = MEM_LB;
        end
        OP_SW, OP_SB: begin
          r.exec_value = a + simm;
          r.mem_kind   = (iw[31:26] == OP_SW) ? MEM_SW : MEM_SB;
          r.store_data = b;
          r.dest_reg   = '0;
          r.reg_write  = 1'b0;
        end
        OP_BEQ, OP_BNE: begin
          r.exec_value = a - b;
          r.dest_reg   = '0;
          r.reg_write  = 1'b0;
          // BEQ taken on equal, BNE taken on not equal
          if ((iw[31:26] == OP_BEQ) == (a == b)) begin
            r.next_pc  = pc4 + (simm << 2);
            r.redirect = 1'b1;
          end
        end
        OP_J, OP_JAL: begin
          r.next_pc  = {pc4[31:28], iw[25:0], 2'b00};
          r.redirect = 1'b1;
          if (iw[31:26] == OP_JAL) begin
            r.exec_value = pc4;
            r.dest_reg   = REG_RA;
          end else begin
            r.dest_reg  = '0;
            r.reg_write = 1'b0;
          end
        end
        default: begin
          r.dest_reg  = '0;
          r.reg_write = 1'b0;
          r.illegal   = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Instruction encoders
  // ---------------------------------------------------------------------
  function automatic word_t r_instr(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                    logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic word_t i_instr(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                    logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic word_t j_instr(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!pacing_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // ---------------------------------------------------------------------
  // Instruction channel driver: one transaction, pushes its prediction
  // at the edge where it is accepted
  // ---------------------------------------------------------------------
  task automatic send_instr(word_t iw, word_t pc, word_t a, word_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_if.valid       <= 1'b1;
    instr_if.instr_word  <= iw;
    instr_if.instr_addr  <= pc;
    instr_if.src_a_value <= a;
    instr_if.src_b_value <= b;
    @(posedge clk);
    while (instr_if.ready !== 1'b1) @(posedge clk);
    exec_results_q.push_back(execute_instr(iw, pc, a, b));
  endtask

  // ---------------------------------------------------------------------
  // Result channel: ready with random stalls
  // ---------------------------------------------------------------------
  initial begin : result_stall_gen
    int hold;
    result_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_checker
    exec_result_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        if (exec_results_q.size() == 0) begin
          $error("result transaction with no instruction outstanding");
          mismatches++;
        end else begin
          want = exec_results_q.pop_front();
          compare_field("exec_value", want.exec_value, result_if.exec_value);
          compare_field("dest_reg",   32'(want.dest_reg),  32'(result_if.dest_reg));
          compare_field("reg_write",  32'(want.reg_write), 32'(result_if.reg_write));
          compare_field("mem_kind",   32'(want.mem_kind),  32'(result_if.mem_kind));
          compare_field("store_data", want.store_data, result_if.store_data);
          compare_field("next_pc",    want.next_pc,    result_if.next_pc);
          compare_field("redirect",   32'(want.redirect),  32'(result_if.redirect));
          compare_field("illegal",    32'(want.illegal),   32'(result_if.illegal));
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Register-register ALU ops, shifts and JR; junk in unused fields.
  task automatic test_r_type_ops();
    send_instr(r_instr(FN_ADDU, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0040_0000,
               32'hffff_ffff, 32'h0000_0001);               // wraps to zero
    send_instr(r_instr(FN_SUBU, 5'd4, 5'd5, 5'd6, 5'd17), 32'h0040_0004,
               32'h0000_0000, 32'h0000_0001);               // borrows to all ones
    send_instr(r_instr(FN_AND, 5'd31, 5'd31, 5'd31, 5'd31), 32'h0040_0008,
               32'hffff_ffff, 32'ha5a5_5a5a);
    send_instr(r_instr(FN_OR, 5'd7, 5'd8, 5'd9, 5'd0), 32'h0040_000c,
               32'h8000_0000, 32'h0000_0001);
    send_instr(r_instr(FN_NOR, 5'd0, 5'd0, 5'd10, 5'd0), 32'h0040_0010,
               32'h0000_0000, 32'h0000_0000);
    // SLTU is unsigned: 0 < 0xffffffff, and not the other way around
    send_instr(r_instr(FN_SLTU, 5'd1, 5'd2, 5'd11, 5'd0), 32'h0040_0014,
               32'h0000_0000, 32'hffff_ffff);
    send_instr(r_instr(FN_SLTU, 5'd1, 5'd2, 5'd11, 5'd0), 32'h0040_0018,
               32'hffff_ffff, 32'h0000_0000);
    // shifts by the largest amount; rs is ignored
    send_instr(r_instr(FN_SLL, 5'd21, 5'd2, 5'd12, 5'd31), 32'h0040_001c,
               32'hdead_beef, 32'h0000_0001);
    send_instr(r_instr(FN_SRL, 5'd21, 5'd2, 5'd13, 5'd31), 32'h0040_0020,
               32'hdead_beef, 32'h8000_0000);               // logical, not arithmetic
    // JR: rt, rd and shamt are ignored
    send_instr(r_instr(FN_JR, 5'd31, 5'd30, 5'd29, 5'd28), 32'h0040_0024,
               32'hdead_beec, 32'h1234_5678);
  endtask

  // Immediate ALU ops: sign- versus zero-extension.
  task automatic test_immediate_ops();
    send_instr(i_instr(OP_ADDIU, 5'd1, 5'd2, 16'h8000), 32'h0040_0100,
               32'h0000_0000, 32'h0);
    send_instr(i_instr(OP_ANDI, 5'd1, 5'd3, 16'hffff), 32'h0040_0104,
               32'hffff_ffff, 32'h0);                       // zero-extended mask
    send_instr(i_instr(OP_ORI, 5'd1, 5'd4, 16'h8000), 32'h0040_0108,
               32'h0000_0000, 32'h0);
    send_instr(i_instr(OP_LUI, 5'd31, 5'd5, 16'hffff), 32'h0040_010c,
               32'h1234_5678, 32'h0);
    // imm 0xffff extends to 0xffffffff, then compared unsigned
    send_instr(i_instr(OP_SLTIU, 5'd1, 5'd6, 16'hffff), 32'h0040_0110,
               32'hffff_fffe, 32'h0);
  endtask

  // Loads and stores: address with negative and positive offsets.
  task automatic test_memory_ops();
    send_instr(i_instr(OP_LW, 5'd29, 5'd8, 16'hfffc), 32'h0040_0200,
               32'h1000_0000, 32'h5555_5555);
    send_instr(i_instr(OP_LB, 5'd29, 5'd9, 16'h7fff), 32'h0040_0204,
               32'hffff_ffff, 32'h5555_5555);
    send_instr(i_instr(OP_SW, 5'd29, 5'd10, 16'h0004), 32'h0040_0208,
               32'h1000_0000, 32'hcafe_f00d);
    send_instr(i_instr(OP_SB, 5'd29, 5'd11, 16'h8000), 32'h0040_020c,
               32'h0000_0000, 32'hffff_ffff);
  endtask

  // Branches taken and not taken, with targets that wrap.
  task automatic test_branches();
    send_instr(i_instr(OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0000_0000,
               32'h0000_1234, 32'h0000_1234);               // taken, backward past zero
    send_instr(i_instr(OP_BEQ, 5'd1, 5'd2, 16'h0010), 32'h0040_0300,
               32'h0000_1234, 32'h0000_1235);               // not taken
    send_instr(i_instr(OP_BNE, 5'd1, 5'd2, 16'h7fff), 32'hffff_fff0,
               32'h0000_0000, 32'hffff_ffff);               // taken, forward past top
    send_instr(i_instr(OP_BNE, 5'd1, 5'd2, 16'h0010), 32'h0040_0304,
               32'h8000_0000, 32'h8000_0000);               // not taken
  endtask

  // J and JAL: region bits come from pc+4, which may wrap.
  task automatic test_jumps();
    send_instr(j_instr(OP_J, 26'h3ff_ffff), 32'h8000_0000, 32'h1111_1111, 32'h2222_2222);
    send_instr(j_instr(OP_JAL, 26'h000_0001), 32'hffff_fffc, 32'h3333_3333, 32'h4444_4444);
  endtask

  // Unsupported encodings, and a write to register zero that is still flagged.
  task automatic test_illegal_and_r0();
    send_instr({OP_UNUSED, 26'h3ff_ffff}, 32'h0040_0400, 32'hffff_ffff, 32'hffff_ffff);
    send_instr(r_instr(FN_UNUSED, 5'd1, 5'd2, 5'd3, 5'd4), 32'h0040_0404,
               32'hffff_ffff, 32'hffff_ffff);
    send_instr(r_instr(FN_ADDU, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0040_0408,
               32'h0000_0005, 32'h0000_0007);
  endtask

  // ---------------------------------------------------------------------
  // Random instructions
  // ---------------------------------------------------------------------
  // Operand mix: corner values a third of the time, otherwise anything.
  function automatic word_t pick_operand();
    case ($urandom_range(0, 8))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly supported encodings with random fields; some random funct codes
  // and raw words for the illegal path.
  function automatic word_t pick_instr();
    word_t iw;
    int    roll;
    iw   = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      iw[31:26] = OP_SPECIAL;
      case ($urandom_range(0, 8))
        0: iw[5:0] = FN_SLL;
        1: iw[5:0] = FN_SRL;
        2: iw[5:0] = FN_JR;
        3: iw[5:0] = FN_ADDU;
        4: iw[5:0] = FN_SUBU;
        5: iw[5:0] = FN_AND;
        6: iw[5:0] = FN_OR;
        7: iw[5:0] = FN_NOR;
        default: iw[5:0] = FN_SLTU;
      endcase
    end else if (roll < 90) begin
      case ($urandom_range(0, 12))
        0: iw[31:26] = OP_J;
        1: iw[31:26] = OP_JAL;
        2: iw[31:26] = OP_BEQ;
        3: iw[31:26] = OP_BNE;
        4: iw[31:26] = OP_ADDIU;
        5: iw[31:26] = OP_SLTIU;
        6: iw[31:26] = OP_ANDI;
        7: iw[31:26] = OP_ORI;
        8: iw[31:26] = OP_LUI;
        9: iw[31:26] = OP_LB;
        10: iw[31:26] = OP_LW;
        11: iw[31:26] = OP_SB;
        default: iw[31:26] = OP_SW;
      endcase
    end else if (roll < 95) begin
      iw[31:26] = OP_SPECIAL;                               // any funct, mostly unsupported
    end
    return iw;
  endfunction

  task automatic test_random_stream(int unsigned count, bit paced);
    word_t iw;
    word_t a;
    word_t b;
    pacing_on = paced;
    repeat (count) begin
      iw = pick_instr();
      a  = pick_operand();
      b  = pick_operand();
      // equal operands often enough that both branch outcomes show up
      if ((iw[31:26] == OP_BEQ || iw[31:26] == OP_BNE) && $urandom_range(0, 2) == 0)
        b = a;
      send_instr(iw, $urandom(), a, b);
    end
    pacing_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    rst                  <= 1'b1;
    instr_if.valid       <= 1'b0;
    instr_if.instr_word  <= '0;
    instr_if.instr_addr  <= '0;
    instr_if.src_a_value <= '0;
    instr_if.src_b_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_r_type_ops();
    test_immediate_ops();
    test_memory_ops();
    test_branches();
    test_jumps();
    test_illegal_and_r0();

    // random phases, one of them back to back with no stalls
    test_random_stream(300, 1'b1);
    test_random_stream(250, 1'b0);
    test_random_stream(300, 1'b1);
    test_random_stream(250, 1'b1);

    // last transaction accepted at this edge; nothing more to send
    instr_if.valid <= 1'b0;
    while (exec_results_q.size() != 0) @(posedge clk);
    // watch a little longer for stray result transactions
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
